// File: design/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types, codes and constants of the pointer position tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int CODE_BITS      = 16;
    localparam int VALUE_BITS     = 32;
    localparam int KIND_BITS      = 4;
    localparam int NUM_KEYS       = 7;
    localparam int KEY_BITS       = 8;
    localparam int CFG_IDX_BITS   = 4;
    localparam int STATUS_BITS    = 2;
    localparam int QUEUE_DEPTH    = 2;

    // event codes on the input side
    localparam logic [CODE_BITS-1:0] CODE_REL_X    = 16'h0000;
    localparam logic [CODE_BITS-1:0] CODE_REL_Y    = 16'h0001;
    localparam logic [CODE_BITS-1:0] CODE_WHEEL    = 16'h0008;
    localparam logic [CODE_BITS-1:0] CODE_HWHEEL   = 16'h0006;
    localparam logic [CODE_BITS-1:0] CODE_BTN_LEFT = 16'h0110;
    localparam logic [CODE_BITS-1:0] CODE_BTN_RGHT = 16'h0111;
    localparam logic [CODE_BITS-1:0] CODE_BTN_MID  = 16'h0112;
    localparam logic [CODE_BITS-1:0] CODE_BTN_SIDE = 16'h0113;
    localparam logic [CODE_BITS-1:0] CODE_BTN_EXTR = 16'h0114;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_X      = 4'd0,
        KIND_Y      = 4'd1,
        KIND_WHEEL  = 4'd2,
        KIND_HWHEEL = 4'd3,
        KIND_LEFT   = 4'd4,
        KIND_RIGHT  = 4'd5,
        KIND_MIDDLE = 4'd6,
        KIND_SIDE   = 4'd7,
        KIND_EXTRA  = 4'd8
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        MAP_NONE   = 2'd0,
        MAP_RAW    = 2'd1,
        MAP_SCALED = 2'd2
    } map_status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCREEN_W = 4'd0,
        CFG_SCREEN_H = 4'd1,
        CFG_TARGET_W = 4'd2,
        CFG_TARGET_H = 4'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        kind_t                         kind;
        logic signed [VALUE_BITS-1:0]  value;
    } event_t;

    typedef struct packed {
        logic   valid;
        event_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: design/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front
// Input side: decodes the event code into a kind and pushes known events.
// ----------------------------------------------------------------------------
module ppt_front
    import ppt_pkg::*;
(
    input  logic                         in_valid,
    input  logic [CODE_BITS-1:0]         event_code,
    input  logic signed [VALUE_BITS-1:0] event_value,
    input  q_status_t                    q_status,
    output logic                         in_stall,
    output q_push_t                      q_push
);

    kind_t kind;
    logic  known;

    always_comb
    begin
        known = 1'b1;
        kind  = KIND_X;
        unique case (event_code)
            CODE_REL_X:    kind = KIND_X;
            CODE_REL_Y:    kind = KIND_Y;
            CODE_WHEEL:    kind = KIND_WHEEL;
            CODE_HWHEEL:   kind = KIND_HWHEEL;
            CODE_BTN_LEFT: kind = KIND_LEFT;
            CODE_BTN_RGHT: kind = KIND_RIGHT;
            CODE_BTN_MID:  kind = KIND_MIDDLE;
            CODE_BTN_SIDE: kind = KIND_SIDE;
            CODE_BTN_EXTR: kind = KIND_EXTRA;
            default:       known = 1'b0;
        endcase
    end

    // unknown codes are taken and dropped
    assign in_stall          = q_status.full;
    assign q_push.valid      = in_valid && !q_status.full && known;
    assign q_push.entry.kind  = kind;
    assign q_push.entry.value = event_value;

endmodule

// File: design/ppt_queue.sv
// ----------------------------------------------------------------------------
// ppt_queue
// Short event queue between the decode side and the execution side.
// ----------------------------------------------------------------------------
module ppt_queue
    import ppt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   q_push,
    input  logic      pop,
    output event_t    head,
    output q_status_t q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    event_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.valid)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (q_push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!q_push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.valid)
            mem_reg[wr_ptr_reg] <= q_push.entry;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: design/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppt_div
    import ppt_pkg::*;
#(
    parameter int DIVIDEND_BITS = 2 * COORD_BITS_DEF,
    parameter int DIVISOR_BITS  = COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     busy,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  dvs_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic [DIVISOR_BITS:0]    trial;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
        quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_BITS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: design/ppt_back.sv
// ----------------------------------------------------------------------------
// ppt_back
// Execution side: cursor update, key store, target mapping, result register.
// ----------------------------------------------------------------------------
module ppt_back
    import ppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  event_t                        head,
    input  q_status_t                     q_status,
    output logic                          pop,
    input  logic [COORD_BITS-1:0]         screen_w,
    input  logic [COORD_BITS-1:0]         screen_h,
    input  logic [COORD_BITS-1:0]         target_w,
    input  logic [COORD_BITS-1:0]         target_h,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [KIND_BITS-1:0]          event_kind,
    output logic                          is_motion,
    output logic signed [COORD_BITS:0]    pos_x,
    output logic signed [COORD_BITS:0]    pos_y,
    output logic signed [COORD_BITS:0]    mapped_x,
    output logic signed [COORD_BITS:0]    mapped_y,
    output logic [STATUS_BITS-1:0]        map_status,
    output logic [NUM_KEYS*KEY_BITS-1:0]  key_values,
    output logic [NUM_KEYS-1:0]           key_seen
);

    localparam int POS_W  = COORD_BITS + 1;
    localparam int SUM_W  = ((VALUE_BITS > POS_W) ? VALUE_BITS : POS_W) + 1;
    localparam int PROD_W = 2 * COORD_BITS;

    // clamp to 0..dim-1; a zero dimension gives 0 for negative, else -1
    function automatic logic signed [POS_W-1:0] clamp_pos(
        input logic signed [SUM_W-1:0] v,
        input logic [COORD_BITS-1:0]   dim
    );
        logic signed [SUM_W-1:0] hi;
        hi = $signed({{(SUM_W-COORD_BITS){1'b0}}, dim}) - $signed(SUM_W'(1));
        if (v[SUM_W-1])
            return '0;
        else if (v > hi)
            return hi[POS_W-1:0];
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_map(
        input logic [PROD_W-1:0]     q,
        input logic [COORD_BITS-1:0] dim
    );
        logic [COORD_BITS-1:0] hi;
        hi = dim - 1'b1;
        if (q > PROD_W'(hi))
            return $signed({1'b0, hi});
        else
            return $signed({1'b0, q[COORD_BITS-1:0]});
    endfunction

    back_state_t state_reg, state_next;

    logic signed [POS_W-1:0]         cursor_x_reg, cursor_y_reg;
    logic [NUM_KEYS*KEY_BITS-1:0]    keys_reg;
    logic [NUM_KEYS-1:0]             seen_reg;
    kind_t                           kind_reg;
    map_status_t                     status_reg, status_calc;

    logic signed [SUM_W-1:0]         sum_x, sum_y;
    logic [PROD_W-1:0]               prod_x, prod_y;
    logic [PROD_W-1:0]               quo_x, quo_y;
    logic                            busy_x, busy_y;

    logic                            div_start;
    logic                            load_out;
    logic                            out_free;

    logic                            out_valid_reg;
    kind_t                           out_kind_reg;
    logic signed [POS_W-1:0]         out_pos_x_reg, out_pos_y_reg;
    logic signed [POS_W-1:0]         out_map_x_reg, out_map_y_reg;
    logic signed [POS_W-1:0]         map_x, map_y;
    map_status_t                     out_status_reg;
    logic [NUM_KEYS*KEY_BITS-1:0]    out_keys_reg;
    logic [NUM_KEYS-1:0]             out_seen_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_MAP;
            ST_MAP:  state_next = (status_calc == MAP_SCALED) ? ST_DIV : ST_DONE;
            ST_DIV:  if (!busy_x && !busy_y) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop       = !q_status.empty;
            ST_MAP:  div_start = (status_calc == MAP_SCALED);
            ST_DIV:  ;
            ST_DONE: load_out  = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        sum_x = SUM_W'(cursor_x_reg);
        sum_y = SUM_W'(cursor_y_reg);
        if (head.kind == KIND_X)
            sum_x = SUM_W'(cursor_x_reg) + SUM_W'(head.value);
        if (head.kind == KIND_Y)
            sum_y = SUM_W'(cursor_y_reg) + SUM_W'(head.value);
    end

    always_comb
    begin
        if (screen_w == '0 || screen_h == '0)
            status_calc = MAP_NONE;
        else if (target_w == '0 || target_h == '0)
            status_calc = MAP_RAW;
        else
            status_calc = MAP_SCALED;
    end

    // cursor is non-negative whenever scaling applies
    assign prod_x = cursor_x_reg[COORD_BITS-1:0] * target_w;
    assign prod_y = cursor_y_reg[COORD_BITS-1:0] * target_h;

    ppt_div #(
        .DIVIDEND_BITS (PROD_W),
        .DIVISOR_BITS  (COORD_BITS)
    ) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x),
        .divisor  (screen_w),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    ppt_div #(
        .DIVIDEND_BITS (PROD_W),
        .DIVISOR_BITS  (COORD_BITS)
    ) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y),
        .divisor  (screen_h),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    always_comb
    begin
        map_x = '0;
        map_y = '0;
        case (status_reg)
            MAP_RAW:
            begin
                map_x = cursor_x_reg;
                map_y = cursor_y_reg;
            end
            MAP_SCALED:
            begin
                map_x = clamp_map(quo_x, screen_w);
                map_y = clamp_map(quo_y, screen_h);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            keys_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                cursor_x_reg <= clamp_pos(sum_x, screen_w);
                cursor_y_reg <= clamp_pos(sum_y, screen_h);
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (head.kind == kind_t'(k + 2))
                    begin
                        keys_reg[k*KEY_BITS +: KEY_BITS] <= head.value[KEY_BITS-1:0];
                        seen_reg[k] <= 1'b1;
                    end
                end
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            kind_reg <= head.kind;
        if (state_reg == ST_MAP)
            status_reg <= status_calc;
        if (load_out)
        begin
            out_kind_reg   <= kind_reg;
            out_pos_x_reg  <= cursor_x_reg;
            out_pos_y_reg  <= cursor_y_reg;
            out_map_x_reg  <= map_x;
            out_map_y_reg  <= map_y;
            out_status_reg <= status_reg;
            out_keys_reg   <= keys_reg;
            out_seen_reg   <= seen_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign is_motion  = (out_kind_reg == KIND_X) || (out_kind_reg == KIND_Y);
    assign pos_x      = out_pos_x_reg;
    assign pos_y      = out_pos_y_reg;
    assign mapped_x   = out_map_x_reg;
    assign mapped_y   = out_map_y_reg;
    assign map_status = out_status_reg;
    assign key_values = out_keys_reg;
    assign key_seen   = out_seen_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !busy_x && !busy_y)
        else $error("divider restarted while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !busy_x && !busy_y)
        else $error("result stage reached with divider still running");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the result stage");

endmodule

// File: design/pointer_position_tracker_unit.sv
// ----------------------------------------------------------------------------
// pointer_position_tracker_unit
// Tracks a pointer cursor from relative-input events and maps it to a target.
//
// Each event transaction (code, signed value) is decoded on entry; unknown
// codes are taken and dropped without a result. Known events wait in a
// two-entry queue and are executed one at a time: X/Y motion is added to
// the cursor, both coordinates are clamped to the screen (a zero dimension
// clamps to -1, or 0 for a negative sum), and wheel/button events latch the
// low byte of the value. Every known event yields one result transaction.
// The execution side pops an event, selects the mapping, and loads the
// result register once the output is free; when scaling applies it first
// waits for the pair of bit-serial dividers that form cursor*target/screen,
// one quotient bit per cycle.
// Configuration registers are written through a separate always-ready port
// and must only change while no event is in flight.
// ----------------------------------------------------------------------------
module pointer_position_tracker_unit
    import ppt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // event input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CODE_BITS-1:0]          event_code,
    input  logic signed [VALUE_BITS-1:0]  event_value,
    // result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [KIND_BITS-1:0]          event_kind,
    output logic                          is_motion,
    output logic signed [COORD_BITS:0]    pos_x,
    output logic signed [COORD_BITS:0]    pos_y,
    output logic signed [COORD_BITS:0]    mapped_x,
    output logic signed [COORD_BITS:0]    mapped_y,
    output logic [STATUS_BITS-1:0]        map_status,
    output logic [NUM_KEYS*KEY_BITS-1:0]  key_values,
    output logic [NUM_KEYS-1:0]           key_seen,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data
);

    logic [COORD_BITS-1:0] screen_w_reg;
    logic [COORD_BITS-1:0] screen_h_reg;
    logic [COORD_BITS-1:0] target_w_reg;
    logic [COORD_BITS-1:0] target_h_reg;

    q_push_t   q_push;
    q_status_t q_status;
    event_t    q_head;
    logic      q_pop;

    // config port never back-pressures; unknown indices are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= '0;
            screen_h_reg <= '0;
            target_w_reg <= '0;
            target_h_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCREEN_W: screen_w_reg <= cfg_data;
                CFG_SCREEN_H: screen_h_reg <= cfg_data;
                CFG_TARGET_W: target_w_reg <= cfg_data;
                CFG_TARGET_H: target_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode side
    ppt_front u_front (
        .in_valid    (in_valid),
        .event_code  (event_code),
        .event_value (event_value),
        .q_status    (q_status),
        .in_stall    (in_stall),
        .q_push      (q_push)
    );

    // decouples decode from execution
    ppt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (q_pop),
        .head     (q_head),
        .q_status (q_status)
    );

    // execution side, owns the cursor, key store and result register
    ppt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_status   (q_status),
        .pop        (q_pop),
        .screen_w   (screen_w_reg),
        .screen_h   (screen_h_reg),
        .target_w   (target_w_reg),
        .target_h   (target_h_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_kind (event_kind),
        .is_motion  (is_motion),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .mapped_x   (mapped_x),
        .mapped_y   (mapped_y),
        .map_status (map_status),
        .key_values (key_values),
        .key_seen   (key_seen)
    );

endmodule
